// File: sv/hash_table_store_probe_unit_assert.svh
// assertion macros for the hash table store and probe unit
`ifndef HASH_TABLE_STORE_PROBE_UNIT_ASSERT_SVH
`define HASH_TABLE_STORE_PROBE_UNIT_ASSERT_SVH

// clocked check, off while reset is high
`define HTSP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define HTSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/hts_pkg.sv
// types and constants shared by the hash table store and probe unit
package hts_pkg;

   localparam int TAG_W   = 32;
   localparam int DATA_W  = 16;
   localparam int BOUND_W = 2;
   localparam int DEPTH_W = 7;
   localparam int AGE_W   = 8;
   localparam int KEY_W   = 64;

   localparam logic             CMD_PROBE   = 1'b0;
   localparam logic             CMD_STORE   = 1'b1;
   localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd3;
   localparam logic [TAG_W-1:0] TAG_EMPTY   = '0;
   localparam logic [DATA_W-1:0] MOVE_NONE  = '0;

   // replacement score terms
   localparam logic signed [2:0] SCORE_ZERO    = 3'sd0;
   localparam logic signed [2:0] SCORE_AGE     = 3'sd2;
   localparam logic signed [2:0] SCORE_PENALTY = 3'sd2;
   localparam logic signed [2:0] SCORE_DEPTH   = 3'sd1;

   typedef struct packed {
      logic                      cmd;
      logic [KEY_W-1:0]          position_key;
      logic signed [DATA_W-1:0]  value_score;
      logic [BOUND_W-1:0]        bound_kind;
      logic signed [7:0]         search_depth;
      logic [DATA_W-1:0]         best_move;
      logic signed [DATA_W-1:0]  static_eval;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [DATA_W-1:0]  found_score;
      logic [BOUND_W-1:0]        found_bound;
      logic [DEPTH_W-1:0]        found_depth;
      logic [DATA_W-1:0]         found_move;
      logic signed [DATA_W-1:0]  found_eval;
      logic [AGE_W-1:0]          found_age;
   } rsp_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [DATA_W-1:0]  score;
      logic [DATA_W-1:0]  move;
      logic [DATA_W-1:0]  eval;
      logic [DEPTH_W-1:0] depth;
      logic [BOUND_W-1:0] bound;
      logic [AGE_W-1:0]   age;
   } entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

// File: sv/hts_req_if.sv
// request channel: valid, ready and one request beat
interface hts_req_if;
   import hts_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/hts_rsp_if.sv
// response channel: valid, ready and one probe result beat
interface hts_rsp_if;
   import hts_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/hts_cluster_mem.sv
// one-port-write one-port-read cluster memory with registered read data
module hts_cluster_mem #(
   parameter int ROW_W = 388,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [ROW_W-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [ROW_W-1:0]         rd_data
);

   logic [ROW_W-1:0] mem_ff [DEPTH];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/hts_way_logic.sv
// probe match and store placement over the ways of one cluster row
module hts_way_logic #(
   parameter int WAYS = 4
) (
   input  hts_pkg::entry_type [WAYS-1:0]  row,
   input  hts_pkg::req_type               item,
   input  logic [hts_pkg::AGE_W-1:0]      search_age,
   output hts_pkg::rsp_type               result,
   output hts_pkg::entry_type [WAYS-1:0]  new_row
);
   import hts_pkg::*;

   localparam int WW = $clog2(WAYS);

   logic [TAG_W-1:0] tag;

   assign tag = item.position_key[KEY_W-1:KEY_W-TAG_W];

   // probe: stop at the first empty way, report the first tag match
   always_comb begin
      logic done;
      done   = 1'b0;
      result = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (!done) begin
            if (row[i].tag == TAG_EMPTY) begin
               done = 1'b1;
            end else if (row[i].tag == tag) begin
               done               = 1'b1;
               result.hit         = 1'b1;
               result.found_score = row[i].score;
               result.found_bound = row[i].bound;
               result.found_depth = row[i].depth;
               result.found_move  = row[i].move;
               result.found_eval  = row[i].eval;
               result.found_age   = row[i].age;
            end
         end
      end
   end

   // store: first empty or matching way, else replacement victim
   always_comb begin
      logic              found;
      logic [WW-1:0]     first_idx;
      logic [WW-1:0]     victim;
      logic [WW-1:0]     target;
      logic signed [2:0] c;
      entry_type         entry;
      found     = 1'b0;
      first_idx = '0;
      victim    = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (!found && (row[i].tag == TAG_EMPTY || row[i].tag == tag)) begin
            found     = 1'b1;
            first_idx = WW'(i);
         end
      end
      for (int i = 0; i < WAYS; i++) begin
         c = (row[victim].age == search_age) ? SCORE_AGE : SCORE_ZERO;
         if (row[i].age == search_age || row[i].bound == BOUND_EXACT) begin
            c = c - SCORE_PENALTY;
         end
         if (row[i].depth < row[victim].depth) begin
            c = c + SCORE_DEPTH;
         end
         if (c > SCORE_ZERO) begin
            victim = WW'(i);
         end
      end
      target      = found ? first_idx : victim;
      entry.tag   = tag;
      entry.score = item.value_score;
      entry.move  = item.best_move;
      if (found && item.best_move == MOVE_NONE) begin
         entry.move = row[first_idx].move;
      end
      entry.eval  = item.static_eval;
      entry.depth = item.search_depth[7] ? '0 : item.search_depth[DEPTH_W-1:0];
      entry.bound = item.bound_kind;
      entry.age   = search_age;
      new_row         = row;
      new_row[target] = entry;
   end

endmodule

// File: sv/hash_table_store_probe_unit.sv
// top level of the set-associative hash table store and probe unit
//
// Requests arrive on req_if; cmd selects probe or store. A probe returns one
// beat on rsp_if carrying hit and the stored fields of the first matching
// way (all zero on a miss); a store returns nothing. csr_wr_en loads the
// search generation from csr_wr_data; the user must assert it only while
// the unit is idle, as the block itself does not enforce this. Each request
// first reads its cluster row from the cluster memory, then compares the
// ways and, for a store, writes the updated row back. The row is written
// before the next read is issued, so back-to-back requests to the same
// cluster always see fresh data. No new request is taken until the last one
// leaves lookup; a probe beat becomes valid once its lookup has loaded the
// output register. After reset the memory is cleared one cluster row per
// cycle, with req_if.ready low; the search generation resets to 0. The probe
// result sits in an output register: a new request is accepted while it
// waits, and only a following probe holds in its compare cycle until
// rsp_if.ready takes the waiting beat.
module hash_table_store_probe_unit #(
   parameter int CLUSTERS = 1024,
   parameter int WAYS     = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   hts_req_if.sink                       req_if,
   hts_rsp_if.source                     rsp_if,
   input  logic                          csr_wr_en,
   input  logic [hts_pkg::AGE_W-1:0]     csr_wr_data
);
   import hts_pkg::*;

`include "hash_table_store_probe_unit_assert.svh"

   localparam int CLW   = $clog2(CLUSTERS);
   localparam int ROW_W = WAYS * $bits(entry_type);

   state_type              state_ff, state_in;
   logic [CLW-1:0]         clr_ff, clr_in;
   logic [AGE_W-1:0]       search_age_ff;
   req_type                item_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff;

   logic                   take_item;
   logic                   load_rsp;
   logic                   mem_we;
   logic [CLW-1:0]         mem_waddr;
   logic [ROW_W-1:0]       mem_wdata;
   logic [ROW_W-1:0]       mem_rdata;
   entry_type [WAYS-1:0]   row;
   entry_type [WAYS-1:0]   new_row;
   rsp_type                result;

   hts_cluster_mem #(
      .ROW_W (ROW_W),
      .DEPTH (CLUSTERS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (take_item),
      .rd_addr (req_if.data.position_key[CLW-1:0]),
      .rd_data (mem_rdata)
   );

   assign row = mem_rdata;

   hts_way_logic #(
      .WAYS (WAYS)
   ) u_ways (
      .row        (row),
      .item       (item_ff),
      .search_age (search_age_ff),
      .result     (result),
      .new_row    (new_row)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_if.ready = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = item_ff.position_key[CLW-1:0];
      mem_wdata    = new_row;
      load_rsp     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == {CLW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (item_ff.cmd == CMD_STORE) begin
               mem_we   = 1'b1;
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_if.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign take_item = req_if.valid && req_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         search_age_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            search_age_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_item) begin
         item_ff <= req_if.data;
      end
      if (load_rsp) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   `HTSP_ASSERT(a_accept_to_lookup, clock, reset,
      (req_if.valid && req_if.ready) |=> (state_ff == ST_LOOKUP),
      "accepted beat did not move to lookup")
   `HTSP_ASSERT(a_rsp_from_probe, clock, reset,
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_LOOKUP && $past(item_ff.cmd) == CMD_PROBE),
      "response raised without a probe lookup")
   `HTSP_ASSERT(a_write_source, clock, reset,
      mem_we |-> (state_ff == ST_CLEAR || (state_ff == ST_LOOKUP && item_ff.cmd == CMD_STORE)),
      "memory written outside clear or store")
   `HTSP_ASSERT_ALWAYS(a_no_accept_in_clear, clock,
      (state_ff == ST_CLEAR) |-> !req_if.ready,
      "request accepted during clearing pass")

endmodule
